### design/swdc_pkg.sv
// Shared constants for the sliding window distinct count block.
`default_nettype none

package swdc_pkg;

    localparam int WINDOW_MAX_DEFAULT = 16;
    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int CFG_BITS           = 5;
    localparam int COUNT_BITS         = 5;

    localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = 5'd4;

endpackage

`default_nettype wire

### design/swdc_cell.sv
// One window cell: a stored value and a flag that marks it as repeated by a newer value.
`default_nettype none

module swdc_cell #(
    parameter int VALUE_BITS = swdc_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  shift_en,
    input  wire logic                  cmp_en,
    input  wire logic [VALUE_BITS-1:0] new_value,
    input  wire logic [VALUE_BITS-1:0] prev_value,
    input  wire logic                  prev_dup,
    output logic      [VALUE_BITS-1:0] value_q,
    output logic                       dup_q,
    output logic                       dup_next
);

    logic [VALUE_BITS-1:0] value_reg;
    logic                  dup_reg;

    // A value moving down becomes a repeat once the incoming value equals it.
    assign dup_next = prev_dup | (cmp_en & (prev_value == new_value));

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            value_reg <= prev_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dup_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            dup_reg <= dup_next;
        end
    end

    assign value_q = value_reg;
    assign dup_q   = dup_reg;

endmodule

`default_nettype wire

### design/swdc_count_tree.sv
// Registered adder tree that counts the set bits of the window's unique mask.
`default_nettype none

module swdc_count_tree #(
    parameter int LEAVES = swdc_pkg::WINDOW_MAX_DEFAULT,
    parameter int CW     = $clog2(LEAVES + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [LEAVES-1:0] leaf_bits,
    output logic                   out_valid,
    output logic      [CW-1:0]     sum
);

    localparam int LEVELS = $clog2(LEAVES);
    localparam int N      = 1 << LEVELS;

    logic [CW-1:0] heap_reg [1:2*N-1];
    logic [LEVELS:0] vld_reg;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_leaf
            if (gi < LEAVES)
            begin : g_used
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        heap_reg[N+gi] <= CW'(leaf_bits[gi]);
                    end
                end
            end
            else
            begin : g_pad
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        heap_reg[N+gi] <= '0;
                    end
                end
            end
        end
        for (gi = 1; gi < N; gi++)
        begin : g_node
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    heap_reg[gi] <= CW'(heap_reg[2*gi] + heap_reg[2*gi+1]);
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LEVELS-1:0], in_valid};
        end
    end

    assign out_valid = vld_reg[LEVELS];
    assign sum       = heap_reg[1];

endmodule

`default_nettype wire

### design/sliding_window_distinct_count.sv
// Top level of the sliding window distinct count block.
`default_nettype none

// Takes one value per clock while the output is not stalled and, once the current array
// holds at least window_size values, returns one distinct count per value for the window
// ending at that value. The values sit in a row of cells, newest first; each cell after the
// head compares the value moving into it with the incoming one, so a new value is taken
// every cycle unless the output stalls. The count goes through a registered adder tree, and
// the block takes a new request whenever the output register is empty or being taken. A
// window_size of zero acts as one; one above WINDOW_MAX acts as WINDOW_MAX. A request with
// first_item set starts a new array with its value.

module sliding_window_distinct_count #(
    parameter int WINDOW_MAX = swdc_pkg::WINDOW_MAX_DEFAULT,
    parameter int VALUE_BITS = swdc_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [swdc_pkg::CFG_BITS-1:0]   cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [VALUE_BITS-1:0]           value,
    input  wire logic                            first_item,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [swdc_pkg::COUNT_BITS-1:0] distinct_count
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int KW = (CW > swdc_pkg::CFG_BITS) ? CW : swdc_pkg::CFG_BITS;
    localparam logic [CW-1:0] FILL_MAX = CW'(WINDOW_MAX);
    localparam logic [KW-1:0] K_MAX    = KW'(WINDOW_MAX);

    logic [swdc_pkg::CFG_BITS-1:0] window_size_reg;
    logic [CW-1:0]                 fill_reg;
    logic [CW-1:0]                 fill_next;
    logic [KW-1:0]                 k_eff;
    logic [KW-1:0]                 ws_ext;
    logic                          advance;
    logic                          accept;
    logic                          produce;
    logic [WINDOW_MAX-1:0]         keep_bits;
    logic [CW-1:0]                 tree_sum;

    logic [VALUE_BITS-1:0] cell_value [WINDOW_MAX];
    logic                  cell_dup   [WINDOW_MAX];
    logic                  cell_dup_next [WINDOW_MAX];

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid || out_ready;
    assign in_ready  = advance;
    assign accept    = in_valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swdc_pkg::WINDOW_SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            window_size_reg <= cfg_data;
        end
    end

    always_comb
    begin
        ws_ext = KW'(window_size_reg);
        if (ws_ext == '0)
        begin
            k_eff = KW'(1);
        end
        else if (ws_ext > K_MAX)
        begin
            k_eff = K_MAX;
        end
        else
        begin
            k_eff = ws_ext;
        end
    end

    always_comb
    begin
        if (first_item)
        begin
            fill_next = CW'(1);
        end
        else if (fill_reg < FILL_MAX)
        begin
            fill_next = CW'(fill_reg + 1'b1);
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
    end

    assign produce = accept && (KW'(fill_next) >= k_eff);

    genvar gj;
    generate
        for (gj = 0; gj < WINDOW_MAX; gj++)
        begin : g_cell
            if (gj == 0)
            begin : g_head
                swdc_cell #(
                    .VALUE_BITS(VALUE_BITS)
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift_en  (accept),
                    .cmp_en    (1'b0),
                    .new_value (value),
                    .prev_value(value),
                    .prev_dup  (1'b0),
                    .value_q   (cell_value[gj]),
                    .dup_q     (cell_dup[gj]),
                    .dup_next  (cell_dup_next[gj])
                );
            end
            else
            begin : g_body
                swdc_cell #(
                    .VALUE_BITS(VALUE_BITS)
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift_en  (accept),
                    .cmp_en    (1'b1),
                    .new_value (value),
                    .prev_value(cell_value[gj-1]),
                    .prev_dup  (cell_dup[gj-1]),
                    .value_q   (cell_value[gj]),
                    .dup_q     (cell_dup[gj]),
                    .dup_next  (cell_dup_next[gj])
                );
            end
            assign keep_bits[gj] = !cell_dup_next[gj] && (KW'(gj) < k_eff);
        end
    endgenerate

    swdc_count_tree #(
        .LEAVES(WINDOW_MAX),
        .CW    (CW)
    ) u_tree (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (produce),
        .leaf_bits(keep_bits),
        .out_valid(out_valid),
        .sum      (tree_sum)
    );

    assign distinct_count = swdc_pkg::COUNT_BITS'(tree_sum);

endmodule

`default_nettype wire

### design/swdc_checker.sv
// Port-level assertions for the sliding window distinct count block, with its bind.
`default_nettype none

module swdc_checker #(
    parameter int WINDOW_MAX = swdc_pkg::WINDOW_MAX_DEFAULT
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_ready,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [swdc_pkg::COUNT_BITS-1:0] distinct_count
);

    // A result that waits holds its count.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distinct_count))
        else $error("pending result changed before it was taken");

    // Requests are refused only while a result waits.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    // A window never holds more distinct values than it has entries, and never none.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (WINDOW_MAX < 32) |->
            (distinct_count != '0) && (int'(distinct_count) <= WINDOW_MAX))
        else $error("distinct count out of range");

endmodule

bind sliding_window_distinct_count swdc_checker #(
    .WINDOW_MAX(WINDOW_MAX)
) u_swdc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .distinct_count(distinct_count)
);

`default_nettype wire
